[src/tmis_pkg.sv]
// Package for the Tiny Machine step block: codes, instruction word layout,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
package tmis_pkg;

    localparam int IMEM_DEPTH_DEF = 1024;
    localparam int DMEM_DEPTH_DEF = 1024;
    localparam int REG_COUNT      = 8;
    localparam int RIDX_W         = 3;
    localparam logic [RIDX_W-1:0] PC_IDX = 3'd7;
    localparam int DIV_STEPS      = 32;

    typedef enum logic [2:0] {
        ACT_LOAD   = 3'd0,
        ACT_STEP   = 3'd1,
        ACT_CLEAR  = 3'd2,
        ACT_RDREG  = 3'd3,
        ACT_RDDATA = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HALT    = 3'd1,
        ST_IFAULT  = 3'd2,
        ST_DFAULT  = 3'd3,
        ST_DIVZERO = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        OP_HALT = 5'd0,
        OP_IN   = 5'd1,
        OP_OUT  = 5'd2,
        OP_ADD  = 5'd3,
        OP_SUB  = 5'd4,
        OP_MUL  = 5'd5,
        OP_DIV  = 5'd6,
        OP_LD   = 5'd8,
        OP_ST   = 5'd9,
        OP_LDA  = 5'd11,
        OP_LDC  = 5'd12,
        OP_JLT  = 5'd13,
        OP_JLE  = 5'd14,
        OP_JGT  = 5'd15,
        OP_JGE  = 5'd16,
        OP_JEQ  = 5'd17,
        OP_JNE  = 5'd18
    } t_opcode;

    // last register-register opcode, and last opcode that checks the data address
    localparam logic [4:0] OP_RR_LAST   = 5'd7;
    localparam logic [4:0] OP_DCHK_LAST = 5'd10;

    typedef struct packed {
        logic [4:0]        op;
        logic [RIDX_W-1:0] ra;
        logic [31:0]       disp;
        logic [RIDX_W-1:0] rb;
    } t_instr;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISPATCH, S_CLEAR, S_DEC, S_RT, S_RR, S_RW, S_EX,
        S_MUL, S_DIV, S_DIVWB, S_LD, S_RDREG, S_RDDATA
    } t_state;

    typedef enum logic [1:0] {RD_A, RD_S, RD_T, RD_R} t_rdsel;
    typedef enum logic [1:0] {WB_ALU, WB_PROD, WB_QUO, WB_DMEM} t_wsel;
    typedef enum logic [1:0] {VS_NONE, VS_REG, VS_DMEM, VS_OUT} t_vsel;

    typedef struct packed {
        logic    in_latch;
        logic    imem_we;
        logic    pc_inc;
        t_rdsel  rd_sel;
        logic    ins_latch;
        logic    cap_s;
        logic    cap_t;
        logic    cap_r;
        logic    cnt_clr;
        logic    sweep;
        logic    sweep_init;
        logic    reg_we;
        t_wsel   wsel;
        logic    jump;
        logic    dm_rd_loc;
        logic    dm_we;
        logic    mul_go;
        logic    div_init;
        logic    div_step;
        logic    finish;
        t_status fin_status;
        t_vsel   vsel;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       pc_fault;
        logic       load_fault;
        logic       loc_fault;
        logic [4:0] op;
        logic       m_fault;
        logic       div_zero;
        logic       cond_true;
        logic       clr_last;
        logic       init_last;
        logic       div_last;
    } t_stat;

endpackage

[src/tmis_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/tmis_ctrl.sv]
// Sequencer for the Tiny Machine step block.
// Depends on tmis_pkg; drives tmis_dpath through t_cmd and watches t_stat.
module tmis_ctrl import tmis_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);
    t_state r_state, n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        cmd            = '0;
        cmd.rd_sel     = RD_A;
        cmd.wsel       = WB_ALU;
        cmd.fin_status = ST_OK;
        cmd.vsel       = VS_NONE;
        unique case (r_state)
            S_INIT: begin
                cmd.sweep      = 1'b1;
                cmd.sweep_init = 1'b1;
                if (i_stat.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    cmd.in_latch = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                cmd.cnt_clr = 1'b1;
                unique case (i_stat.action)
                    ACT_LOAD: begin
                        cmd.imem_we    = !i_stat.load_fault;
                        cmd.finish     = 1'b1;
                        cmd.fin_status = i_stat.load_fault ? ST_IFAULT : ST_OK;
                        n_state        = S_IDLE;
                    end
                    ACT_STEP: begin
                        if (i_stat.pc_fault) begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_IFAULT;
                            n_state        = S_IDLE;
                        end else begin
                            cmd.pc_inc = 1'b1;
                            n_state    = S_DEC;
                        end
                    end
                    ACT_CLEAR: n_state = S_CLEAR;
                    ACT_RDREG: n_state = S_RDREG;
                    ACT_RDDATA: begin
                        if (i_stat.loc_fault) begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_DFAULT;
                            n_state        = S_IDLE;
                        end else begin
                            cmd.dm_rd_loc = 1'b1;
                            n_state       = S_RDDATA;
                        end
                    end
                    default: begin
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_CLEAR: begin
                cmd.sweep = 1'b1;
                if (i_stat.clr_last) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DEC: begin
                cmd.ins_latch = 1'b1;
                cmd.rd_sel    = RD_S;
                n_state       = S_RT;
            end
            S_RT: begin
                cmd.cap_s  = 1'b1;
                cmd.rd_sel = RD_T;
                n_state    = S_RR;
            end
            S_RR: begin
                cmd.cap_t  = 1'b1;
                cmd.rd_sel = RD_R;
                n_state    = S_RW;
            end
            S_RW: begin
                cmd.cap_r = 1'b1;
                n_state   = S_EX;
            end
            S_EX: begin
                cmd.finish = 1'b1;
                n_state    = S_IDLE;
                if (i_stat.m_fault) begin
                    cmd.fin_status = ST_DFAULT;
                end else begin
                    unique case (i_stat.op) inside
                        OP_HALT: cmd.fin_status = ST_HALT;
                        OP_IN, OP_ADD, OP_SUB, OP_LDA, OP_LDC: cmd.reg_we = 1'b1;
                        OP_OUT: cmd.vsel = VS_OUT;
                        OP_MUL: begin
                            cmd.finish = 1'b0;
                            cmd.mul_go = 1'b1;
                            n_state    = S_MUL;
                        end
                        OP_DIV: begin
                            if (i_stat.div_zero) begin
                                cmd.fin_status = ST_DIVZERO;
                            end else begin
                                cmd.finish   = 1'b0;
                                cmd.div_init = 1'b1;
                                cmd.cnt_clr  = 1'b1;
                                n_state      = S_DIV;
                            end
                        end
                        OP_LD: begin
                            cmd.finish = 1'b0;
                            n_state    = S_LD;
                        end
                        OP_ST: cmd.dm_we = 1'b1;
                        OP_JLT, OP_JLE, OP_JGT, OP_JGE, OP_JEQ, OP_JNE:
                            cmd.jump = i_stat.cond_true;
                        default: ;
                    endcase
                end
            end
            S_MUL: begin
                cmd.reg_we = 1'b1;
                cmd.wsel   = WB_PROD;
                cmd.finish = 1'b1;
                n_state    = S_IDLE;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_DIVWB;
            end
            S_DIVWB: begin
                cmd.reg_we = 1'b1;
                cmd.wsel   = WB_QUO;
                cmd.finish = 1'b1;
                n_state    = S_IDLE;
            end
            S_LD: begin
                cmd.reg_we = 1'b1;
                cmd.wsel   = WB_DMEM;
                cmd.finish = 1'b1;
                n_state    = S_IDLE;
            end
            S_RDREG: begin
                cmd.vsel   = VS_REG;
                cmd.finish = 1'b1;
                n_state    = S_IDLE;
            end
            S_RDDATA: begin
                cmd.vsel   = VS_DMEM;
                cmd.finish = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);
endmodule

[src/tmis_dpath.sv]
// Datapath: register file, instruction and data stores, ALU, multiplier,
// radix-2 divider, sweep counter and result registers. Depends on tmis_pkg, tmis_ram.
module tmis_dpath import tmis_pkg::*; #(
    parameter int IMEM_DEPTH = IMEM_DEPTH_DEF,
    parameter int DMEM_DEPTH = DMEM_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [2:0]  i_action,
    input  logic [9:0]  i_location,
    input  logic [4:0]  i_opcode,
    input  logic [2:0]  i_reg_a,
    input  logic signed [31:0] i_displacement,
    input  logic [2:0]  i_reg_b,
    input  logic signed [31:0] i_in_value,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic        o_value_valid,
    output logic signed [31:0] o_value,
    output logic signed [31:0] o_program_counter
);
    localparam int IA   = $clog2(IMEM_DEPTH);
    localparam int DA   = $clog2(DMEM_DEPTH);
    localparam int MAXD = (IMEM_DEPTH > DMEM_DEPTH) ? IMEM_DEPTH : DMEM_DEPTH;
    localparam int CW   = $clog2(MAXD) + 1;

    // latched item
    logic [2:0]  r_action;
    logic [9:0]  r_loc;
    t_instr      r_new;
    logic [31:0] r_in_value;

    logic [31:0] r_pc;
    t_instr      r_ins;
    logic [RIDX_W-1:0] r_ridx;
    logic [31:0] r_vs, r_vt, r_vr, r_prod;
    logic [31:0] r_dq, r_rem, r_dvs;
    logic        r_qneg;
    logic [CW-1:0] r_cnt;

    logic        r_done, r_valid;
    logic [2:0]  r_status;
    logic [31:0] r_value;

    t_instr      imem_q;
    logic [31:0] dmem_q, rf_q, rd_val, m, alu, wdata, quo;
    logic [RIDX_W-1:0] raddr, s_idx;
    logic [31:0] loc_ext;
    logic        imem_we, dmem_we, rf_we, rr_form;
    logic [IA-1:0] imem_waddr;
    logic [DA-1:0] dmem_waddr, dmem_raddr;
    logic [31:0] dmem_wdata;
    t_instr      imem_wdata;
    logic [RIDX_W-1:0] rf_waddr;
    logic [31:0] rf_wdata;
    logic [32:0] rem_sh, diff;
    logic [31:0] mag_s, mag_t;

    assign loc_ext = {22'd0, r_loc};
    assign rd_val  = (r_ridx == PC_IDX) ? r_pc : rf_q;
    assign rr_form = (r_ins.op <= OP_RR_LAST);
    assign m       = r_ins.disp + r_vs;

    // register read address
    always_comb begin
        s_idx = (imem_q.op <= OP_RR_LAST) ? imem_q.disp[RIDX_W-1:0] : imem_q.rb;
        case (i_cmd.rd_sel)
            RD_S:    raddr = s_idx;
            RD_T:    raddr = r_ins.rb;
            RD_R:    raddr = r_ins.ra;
            default: raddr = r_new.ra;
        endcase
    end

    always_comb begin
        case (r_ins.op)
            OP_IN:   alu = r_in_value;
            OP_ADD:  alu = r_vs + r_vt;
            OP_SUB:  alu = r_vs - r_vt;
            OP_LDA:  alu = m;
            OP_LDC:  alu = r_ins.disp;
            default: alu = '0;
        endcase
        quo = r_qneg ? (32'd0 - r_dq) : r_dq;
        case (i_cmd.wsel)
            WB_PROD: wdata = r_prod;
            WB_QUO:  wdata = quo;
            WB_DMEM: wdata = dmem_q;
            default: wdata = alu;
        endcase
    end

    // write ports: sweep has priority
    always_comb begin
        imem_we    = i_cmd.imem_we;
        imem_waddr = IA'(loc_ext);
        imem_wdata = r_new;
        dmem_we    = i_cmd.dm_we;
        dmem_waddr = m[DA-1:0];
        dmem_wdata = r_vr;
        rf_we      = i_cmd.reg_we && (r_ins.ra != PC_IDX);
        rf_waddr   = r_ins.ra;
        rf_wdata   = wdata;
        if (i_cmd.sweep) begin
            imem_we    = i_cmd.sweep_init && (r_cnt < CW'(IMEM_DEPTH));
            imem_waddr = r_cnt[IA-1:0];
            imem_wdata = '0;
            dmem_we    = (r_cnt < CW'(DMEM_DEPTH));
            dmem_waddr = r_cnt[DA-1:0];
            dmem_wdata = (r_cnt == '0) ? 32'(DMEM_DEPTH - 1) : 32'd0;
            rf_we      = (r_cnt < CW'(REG_COUNT));
            rf_waddr   = r_cnt[RIDX_W-1:0];
            rf_wdata   = '0;
        end
        dmem_raddr = i_cmd.dm_rd_loc ? DA'(loc_ext) : m[DA-1:0];
    end

    tmis_ram #(.WIDTH($bits(t_instr)), .DEPTH(IMEM_DEPTH)) u_imem (
        .i_clk, .i_we(imem_we), .i_waddr(imem_waddr), .i_wdata(imem_wdata),
        .i_raddr(r_pc[IA-1:0]), .o_rdata(imem_q)
    );

    tmis_ram #(.WIDTH(32), .DEPTH(DMEM_DEPTH)) u_dmem (
        .i_clk, .i_we(dmem_we), .i_waddr(dmem_waddr), .i_wdata(dmem_wdata),
        .i_raddr(dmem_raddr), .o_rdata(dmem_q)
    );

    tmis_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf (
        .i_clk, .i_we(rf_we), .i_waddr(rf_waddr), .i_wdata(rf_wdata),
        .i_raddr(raddr), .o_rdata(rf_q)
    );

    // divider step: shift-subtract on magnitudes
    assign rem_sh = {r_rem, r_dq[31]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign mag_s  = r_vs[31] ? (32'd0 - r_vs) : r_vs;
    assign mag_t  = r_vt[31] ? (32'd0 - r_vt) : r_vt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_latch) begin
            r_action   <= i_action;
            r_loc      <= i_location;
            r_new      <= '{op: i_opcode, ra: i_reg_a, disp: i_displacement, rb: i_reg_b};
            r_in_value <= i_in_value;
        end
        r_ridx <= raddr;
        if (i_cmd.ins_latch) r_ins <= imem_q;
        if (i_cmd.cap_s) r_vs <= rd_val;
        if (i_cmd.cap_t) r_vt <= rd_val;
        if (i_cmd.cap_r) r_vr <= rd_val;
        if (i_cmd.mul_go) r_prod <= r_vs * r_vt;
        if (i_cmd.div_init) begin
            r_dq   <= mag_s;
            r_rem  <= '0;
            r_dvs  <= mag_t;
            r_qneg <= r_vs[31] ^ r_vt[31];
        end else if (i_cmd.div_step) begin
            r_rem <= diff[32] ? rem_sh[31:0] : diff[31:0];
            r_dq  <= {r_dq[30:0], !diff[32]};
        end
        if (i_cmd.finish) begin
            r_status <= i_cmd.fin_status;
            r_valid  <= (i_cmd.vsel != VS_NONE);
            case (i_cmd.vsel)
                VS_REG:  r_value <= rd_val;
                VS_DMEM: r_value <= dmem_q;
                VS_OUT:  r_value <= r_vr;
                default: r_value <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_pc   <= '0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.sweep || i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.sweep) begin
                r_pc <= '0;
            end else if (i_cmd.reg_we && (r_ins.ra == PC_IDX)) begin
                r_pc <= wdata;
            end else if (i_cmd.jump) begin
                r_pc <= m;
            end else if (i_cmd.pc_inc) begin
                r_pc <= r_pc + 32'd1;
            end
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.action     = r_action;
        o_stat.pc_fault   = r_pc[31] || (r_pc >= 32'(IMEM_DEPTH));
        o_stat.load_fault = (loc_ext >= 32'(IMEM_DEPTH));
        o_stat.loc_fault  = (loc_ext >= 32'(DMEM_DEPTH));
        o_stat.op         = r_ins.op;
        o_stat.m_fault    = !rr_form && (r_ins.op <= OP_DCHK_LAST)
                            && (m[31] || (m >= 32'(DMEM_DEPTH)));
        o_stat.div_zero   = (r_vt == '0);
        case (r_ins.op)
            OP_JLT:  o_stat.cond_true = r_vr[31];
            OP_JLE:  o_stat.cond_true = r_vr[31] || (r_vr == '0);
            OP_JGT:  o_stat.cond_true = !r_vr[31] && (r_vr != '0);
            OP_JGE:  o_stat.cond_true = !r_vr[31];
            OP_JEQ:  o_stat.cond_true = (r_vr == '0);
            OP_JNE:  o_stat.cond_true = (r_vr != '0);
            default: o_stat.cond_true = 1'b0;
        endcase
        o_stat.clr_last   = (r_cnt == CW'(DMEM_DEPTH - 1));
        o_stat.init_last  = (r_cnt == CW'(MAXD - 1));
        o_stat.div_last   = (r_cnt == CW'(DIV_STEPS - 1));
    end

    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_value_valid     = r_valid;
    assign o_value           = r_value;
    assign o_program_counter = r_pc;
endmodule

[src/tiny_machine_instruction_step.sv]
// From the transfer in to the result strobe: load, unused actions and a faulting fetch or
// data read finish at dispatch, other reads add a read state; a step runs decode, operand
// reads and execute (MUL and LD add a write-back state, DIV 32 shift-subtract steps and a
// write-back); clear sweeps the data store and register file. A new item is taken in the
// same cycle as the strobe; while busy with one item the block takes no other.
// After reset the block is busy while one sweep clears the instruction store, the registers
// and the data store but word 0 (DMEM_DEPTH - 1); the receiver cannot stall results.
module tiny_machine_instruction_step import tmis_pkg::*; #(
    parameter int IMEM_DEPTH = IMEM_DEPTH_DEF,
    parameter int DMEM_DEPTH = DMEM_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [9:0]  i_location,
    input  logic [4:0]  i_opcode,
    input  logic [2:0]  i_reg_a,
    input  logic signed [31:0] i_displacement,
    input  logic [2:0]  i_reg_b,
    input  logic signed [31:0] i_in_value,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic        o_value_valid,
    output logic signed [31:0] o_value,
    output logic signed [31:0] o_program_counter
);
    // Controller and datapath talk only through these two bundles.
    t_cmd  cmd;
    t_stat stat;

    // sequencer: dispatch, operand fetch, execute, multi-cycle units, sweeps
    tmis_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_start(start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    // stores, PC, ALU, multiplier, divider; results held from one strobe to the next
    tmis_dpath #(.IMEM_DEPTH(IMEM_DEPTH), .DMEM_DEPTH(DMEM_DEPTH)) u_dpath (
        .i_clk, .i_rst_n,
        .i_cmd (cmd),
        .o_stat(stat),
        .i_action, .i_location, .i_opcode, .i_reg_a, .i_displacement, .i_reg_b,
        .i_in_value,
        .o_done, .o_status, .o_value_valid, .o_value, .o_program_counter
    );
endmodule

[src/tmis_chk.sv]
// Port-level checks for the Tiny Machine step block, bound to the top level.
// Depends on tmis_pkg and the tiny_machine_instruction_step ports.
module tmis_chk import tmis_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic        o_value_valid,
    input logic [31:0] o_value
);
    // result strobe only appears once the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("strobe while busy");

    // a transfer in makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("transfer did not start work");

    // each item gives a single result
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result repeated");

    // at a strobe, value is zero unless marked valid
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_value_valid) |-> (o_value == '0)) else $error("stray value");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status <= ST_DIVZERO)) else $error("bad status code");
endmodule

bind tiny_machine_instruction_step tmis_chk u_tmis_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_done(o_done),
    .o_status(o_status), .o_value_valid(o_value_valid), .o_value(o_value)
);

[tb/sv/tb.sv]
// Self-checking testbench for tiny_machine_instruction_step: a directed table, then random
// Tiny Machine programs, each result checked against the table or a predictor of the machine state.
// Depends on tmis_pkg and the block under test.
`timescale 1ns / 100ps

module tb;
    import tmis_pkg::*;

    localparam int  IMEM_D        = 1024;
    localparam int  DMEM_D        = 1024;
    localparam int  N_RANDOM      = 1400;
    localparam int  CYCLE_LIMIT   = 1000000;
    localparam int  TAIL_CYCLES   = 60;      // longest latency is a clear, handled by drain
    localparam int  MAX_CLEARS    = 60;
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;   // actions 5..7 do nothing
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam logic [4:0] OP_DCHK_ONLY = 5'd10;  // undefined, but still address-checked
    localparam logic [4:0] OP_UNDEF_HI  = 5'd31;

    typedef struct packed {
        logic [2:0]  act;
        logic [9:0]  loc;
        logic [4:0]  op;
        logic [2:0]  ra;
        logic [31:0] disp;
        logic [2:0]  rb;
        logic [31:0] inval;
    } tm_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        vvalid;
        logic [31:0] value;
        logic [31:0] pc;
    } tm_result_t;

    typedef struct packed {
        tm_item_t   item;
        logic       typed;   // expected result written into the table
        tm_result_t res;
    } tm_row_t;

    // ---------------------------------------------------------------- DUT hookup
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_action;
    logic [9:0]  i_location;
    logic [4:0]  i_opcode;
    logic [2:0]  i_reg_a;
    logic signed [31:0] i_displacement;
    logic [2:0]  i_reg_b;
    logic signed [31:0] i_in_value;
    logic        o_done;
    logic [2:0]  o_status;
    logic        o_value_valid;
    logic signed [31:0] o_value;
    logic signed [31:0] o_program_counter;

    tiny_machine_instruction_step #(.IMEM_DEPTH(IMEM_D), .DMEM_DEPTH(DMEM_D)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_location(i_location), .i_opcode(i_opcode),
        .i_reg_a(i_reg_a), .i_displacement(i_displacement), .i_reg_b(i_reg_b),
        .i_in_value(i_in_value), .o_done(o_done), .o_status(o_status),
        .o_value_valid(o_value_valid), .o_value(o_value),
        .o_program_counter(o_program_counter)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------- machine model
    logic [31:0] tm_regs [REG_COUNT];
    t_instr      tm_imem [IMEM_D];
    logic [31:0] tm_dmem [DMEM_D];

    tm_result_t  expected_q [$];
    tm_row_t     directed_rows [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          clears = 0;

    function automatic void wipe_machine();
        for (int k = 0; k < REG_COUNT; k++) tm_regs[k] = '0;
        for (int k = 0; k < DMEM_D; k++) tm_dmem[k] = '0;
        tm_dmem[0] = 32'(DMEM_D - 1);
    endfunction

    function automatic logic [31:0] div_toward_zero(logic [31:0] a, logic [31:0] b);
        logic [31:0] ua, ub, q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q  = ua / ub;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    // executes one instruction at the PC; status is returned, OUT fills res
    function automatic logic [2:0] exec_instr(logic [31:0] inval, ref tm_result_t res);
        logic [31:0] pc, m, rv;
        t_instr      w;
        logic [2:0]  r, s, t;
        pc = tm_regs[PC_IDX];
        if (pc[31] || pc >= IMEM_D) return ST_IFAULT;
        tm_regs[PC_IDX] = pc + 1;
        w = tm_imem[pc];
        r = w.ra;
        m = '0;
        if (w.op <= OP_RR_LAST) begin
            s = w.disp[2:0];
            t = w.rb;
        end else begin
            s = w.rb;
            t = '0;
            m = w.disp + tm_regs[s];
            if (w.op <= OP_DCHK_LAST && (m[31] || m >= DMEM_D)) return ST_DFAULT;
        end
        rv = tm_regs[r];
        case (w.op)
            OP_HALT: return ST_HALT;
            OP_IN:   tm_regs[r] = inval;
            OP_OUT: begin
                res.value  = rv;
                res.vvalid = 1'b1;
            end
            OP_ADD:  tm_regs[r] = tm_regs[s] + tm_regs[t];
            OP_SUB:  tm_regs[r] = tm_regs[s] - tm_regs[t];
            OP_MUL:  tm_regs[r] = tm_regs[s] * tm_regs[t];
            OP_DIV: begin
                if (tm_regs[t] == 0) return ST_DIVZERO;
                tm_regs[r] = div_toward_zero(tm_regs[s], tm_regs[t]);
            end
            OP_LD:   tm_regs[r] = tm_dmem[m];
            OP_ST:   tm_dmem[m] = rv;
            OP_LDA:  tm_regs[r] = m;
            OP_LDC:  tm_regs[r] = w.disp;
            OP_JLT:  if (rv[31]) tm_regs[PC_IDX] = m;
            OP_JLE:  if (rv[31] || rv == 0) tm_regs[PC_IDX] = m;
            OP_JGT:  if (!rv[31] && rv != 0) tm_regs[PC_IDX] = m;
            OP_JGE:  if (!rv[31]) tm_regs[PC_IDX] = m;
            OP_JEQ:  if (rv == 0) tm_regs[PC_IDX] = m;
            OP_JNE:  if (rv != 0) tm_regs[PC_IDX] = m;
            default: ;
        endcase
        return ST_OK;
    endfunction

    // updates the model for one transfer and returns the result it should produce
    function automatic tm_result_t predict_machine(tm_item_t it);
        tm_result_t res;
        res = '0;
        res.status = ST_OK;
        case (it.act)
            ACT_LOAD: tm_imem[it.loc] = '{op: it.op, ra: it.ra, disp: it.disp, rb: it.rb};
            ACT_STEP: res.status = exec_instr(it.inval, res);
            ACT_CLEAR: wipe_machine();
            ACT_RDREG: begin
                res.value  = tm_regs[it.ra];
                res.vvalid = 1'b1;
            end
            ACT_RDDATA: begin
                res.value  = tm_dmem[it.loc];
                res.vvalid = 1'b1;
            end
            default: ;
        endcase
        res.pc = tm_regs[PC_IDX];
        return res;
    endfunction

    // ---------------------------------------------------------------- sender
    // Holds the item on the ports until a transfer edge (start high, busy low).
    // start is left high; the caller lowers it only when idling follows.
    task automatic issue_item(tm_item_t it, logic typed, tm_result_t typed_res);
        tm_result_t pr;
        start          <= 1'b1;
        i_action       <= it.act;
        i_location     <= it.loc;
        i_opcode       <= it.op;
        i_reg_a        <= it.ra;
        i_displacement <= it.disp;
        i_reg_b        <= it.rb;
        i_in_value     <= it.inval;
        do @(posedge i_clk); while (busy);
        pr = predict_machine(it);
        expected_q.push_back(typed ? typed_res : pr);
    endtask

    task automatic hold_off(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic tm_row_t mk_row(logic [2:0] act, logic [9:0] loc, logic [4:0] op,
                                       logic [2:0] ra, logic [31:0] disp, logic [2:0] rb,
                                       logic [31:0] inval, logic typed, logic [2:0] st,
                                       logic vv, logic [31:0] val, logic [31:0] pc);
        tm_row_t row;
        row.item  = '{act: act, loc: loc, op: op, ra: ra, disp: disp, rb: rb, inval: inval};
        row.typed = typed;
        row.res   = '{status: st, vvalid: vv, value: val, pc: pc};
        return row;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            4, 5: return $urandom();
            6: return -$urandom_range(1, 8);
            default: return $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [4:0] rand_opcode();
        case ($urandom_range(0, 15))
            0: return $urandom_range(0, OP_UNDEF_HI);
            1: return OP_IN;
            2: return OP_OUT;
            3: return OP_ADD;
            4: return OP_SUB;
            5: return OP_MUL;
            6: return OP_DIV;
            7: return OP_LD;
            8: return OP_ST;
            9: return OP_LDA;
            10: return OP_LDC;
            11: return OP_HALT;
            default: return $urandom_range(OP_JLT, OP_JNE);
        endcase
    endfunction

    // mostly small programs in the low instruction store, stepped often
    function automatic tm_item_t rand_item();
        tm_item_t it;
        int       pick;
        it.loc   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
        it.op    = rand_opcode();
        it.ra    = $urandom_range(0, 7);
        it.rb    = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 3'd0;
        it.disp  = ($urandom_range(0, 2) == 0) ? rand_word() : $urandom_range(0, 31);
        it.inval = rand_word();
        pick = $urandom_range(0, 99);
        if (pick < 33)      it.act = ACT_LOAD;
        else if (pick < 80) it.act = ACT_STEP;
        else if (pick < 89) it.act = ACT_RDREG;
        else if (pick < 97) it.act = ACT_RDDATA;
        else if (pick < 98 && clears < MAX_CLEARS) it.act = ACT_CLEAR;
        else                it.act = $urandom_range(ACT_SPARE_LO, ACT_SPARE_HI);
        return it;
    endfunction

    // ---------------------------------------------------------------- checker
    // Results cannot be held off: each strobe is checked at the edge that ends it.
    always @(posedge i_clk) begin
        tm_result_t got, want;
        if (i_rst_n && o_done) begin
            got = '{status: o_status, vvalid: o_value_valid, value: o_value,
                    pc: o_program_counter};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: st=%0d vv=%0d val=%h pc=%h",
                             $realtime, got.status, got.vvalid, got.value, got.pc);
            end else begin
                want = expected_q.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: mismatch exp st=%0d vv=%0d val=%h pc=%h, ",
                                  "got st=%0d vv=%0d val=%h pc=%h"},
                                 $realtime, want.status, want.vvalid, want.value, want.pc,
                                 got.status, got.vvalid, got.value, got.pc);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial begin
        tm_item_t it;
        tm_row_t  row;
        int       gap;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_action       <= ACT_RDREG;
        i_location     <= '0;
        i_opcode       <= OP_HALT;
        i_reg_a        <= '0;
        i_displacement <= '0;
        i_reg_b        <= '0;
        i_in_value     <= '0;
        wipe_machine();
        for (int k = 0; k < IMEM_D; k++) tm_imem[k] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Typed results only where obvious; the rest go to the predictor.
        // Reset state, HALT at 0, spare actions.
        directed_rows.push_back(mk_row(ACT_RDREG, 0, OP_HALT, 7, 0, 0, 0, 1, ST_OK, 1, 0, 0));
        directed_rows.push_back(mk_row(ACT_RDDATA, 0, OP_HALT, 0, 0, 0, 0, 1, ST_OK, 1, 1023, 0));
        directed_rows.push_back(mk_row(ACT_RDDATA, 1023, OP_HALT, 0, 0, 0, 0, 1, ST_OK, 1, 0, 0));
        directed_rows.push_back(mk_row(ACT_STEP, 0, OP_HALT, 0, 0, 0, 0, 1, ST_HALT, 0, 0, 1));
        directed_rows.push_back(mk_row(ACT_SPARE_LO, 1023, OP_UNDEF_HI, 7, 32'hffff_ffff, 7,
                                       32'hffff_ffff, 1, ST_OK, 0, 0, 1));
        directed_rows.push_back(mk_row(ACT_SPARE_HI, 0, OP_HALT, 0, 0, 0, 0, 1, ST_OK, 0, 0, 1));
        // program at 1..9: most negative / -1, divide by zero, store at the top word,
        // load one past the end, OUT, undefined opcode, taken jump to the last address
        directed_rows.push_back(mk_row(ACT_LOAD, 1, OP_LDC, 1, 32'h8000_0000, 0, 0,
                                       1, ST_OK, 0, 0, 1));
        directed_rows.push_back(mk_row(ACT_LOAD, 2, OP_LDC, 2, 32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_LOAD, 3, OP_DIV, 3, 1, 2, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_LOAD, 4, OP_DIV, 4, 1, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_LOAD, 5, OP_ST, 1, 1023, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_LOAD, 6, OP_LD, 5, 1024, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_LOAD, 7, OP_OUT, 3, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_LOAD, 8, OP_DCHK_ONLY, 0, 32'hffff_ffff, 0, 0,
                                       0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ACT_LOAD, 9, OP_JNE, 1, 1023, 0, 0, 0, 0, 0, 0, 0));
        for (int k = 0; k < 9; k++)
            directed_rows.push_back(mk_row(ACT_STEP, 0, OP_HALT, 0, 0, 0, 32'h7fff_ffff,
                                           0, 0, 0, 0, 0));
        // HALT at 1023 leaves the PC at 1024: the next fetch faults
        directed_rows.push_back(mk_row(ACT_STEP, 0, OP_HALT, 0, 0, 0, 0, 1, ST_HALT, 0, 0, 1024));
        directed_rows.push_back(mk_row(ACT_STEP, 0, OP_HALT, 0, 0, 0, 0, 1, ST_IFAULT, 0, 0, 1024));
        directed_rows.push_back(mk_row(ACT_CLEAR, 0, OP_HALT, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0));

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            issue_item(row.item, row.typed, row.res);
        end

        // Random programs. Once the PC has run off the instruction store only a clear helps.
        for (int n = 0; n < N_RANDOM; n++) begin
            it = rand_item();
            if ((tm_regs[PC_IDX][31] || tm_regs[PC_IDX] >= IMEM_D) && clears < MAX_CLEARS
                && $urandom_range(0, 3) == 0)
                it.act = ACT_CLEAR;
            if (it.act == ACT_CLEAR) clears++;
            issue_item(it, 1'b0, '0);
            if (n == N_RANDOM / 2) begin
                // pause until the block has caught up completely
                start <= 1'b0;
                wait_drained();
            end else if (n < N_RANDOM * 85 / 100 && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 10);
                hold_off(gap);
            end
        end
        start <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
src/tmis_pkg.sv
src/tmis_ram.sv
src/tmis_ctrl.sv
src/tmis_dpath.sv
src/tiny_machine_instruction_step.sv
src/tmis_chk.sv
tb/sv/tb.sv
